// ===== src/rlne_pkg.sv =====
// ----------------------------------------------------------------------------
// rlne_pkg
// Shared types and constants for the rhombic lattice neighbor/edge index core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rlne_pkg;

    localparam int VERTEX_W  = 22;
    localparam int EDGE_W    = 24;
    localparam int LSIZE_W   = 7;
    localparam int COORD_W   = 6;
    localparam int LY_W      = 9;
    localparam int PLANE_W   = 15;
    localparam int VOL_W     = 21;
    localparam int RECIP_L_W = 22;
    localparam int RECIP_Y_W = 16;
    localparam int Q1_W      = 16;
    localparam int Q2_W      = 7;
    localparam int SHIFT_L   = 22;
    localparam int SHIFT_Y   = 16;

    // One reciprocal bit is produced per setup cycle, most significant first.
    localparam int SETUP_CYCLES = SHIFT_L + 1;
    localparam int SETUP_CNT_W  = 5;

    localparam logic [1:0] DIR_XY  = 2'd0;
    localparam logic [1:0] DIR_XZ  = 2'd1;
    localparam logic [1:0] DIR_YZ  = 2'd2;
    localparam logic [1:0] DIR_XYZ = 2'd3;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex;
        logic [1:0]          direction;
        logic                negative;
    } rlne_in_t;

    typedef struct packed {
        logic [VERTEX_W-1:0] neighbor;
        logic [EDGE_W-1:0]   edge_res;
        logic                out_of_range;
    } rlne_out_t;

    typedef struct packed {
        logic [LSIZE_W-1:0]   lsize;
        logic [LY_W-1:0]      ly;
        logic [PLANE_W-1:0]   plane;
        logic [VOL_W-1:0]     vol;
        logic [VERTEX_W-1:0]  total;
        logic [RECIP_L_W-1:0] recip_l;
        logic [RECIP_Y_W-1:0] recip_y;
    } rlne_geom_t;

    typedef struct packed {
        logic [VERTEX_W-1:0] vertex;
        logic [1:0]          direction;
        logic                negative;
        logic                oor;
    } rlne_tag_t;

    typedef struct packed {
        rlne_tag_t          tag;
        logic [COORD_W-1:0] x;
        logic [LY_W-1:0]    y;
        logic [COORD_W-1:0] z;
        logic               w;
    } rlne_item_t;

endpackage

// ===== src/rlne_setup.sv =====
// ----------------------------------------------------------------------------
// rlne_setup
// Holds the lattice size and derives extents and division reciprocals.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rlne_setup
    import rlne_pkg::*;
#(
    parameter int MAX_LATTICE = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [LSIZE_W-1:0] cfg_data,
    output rlne_geom_t         geom,
    output logic               settling
);

    localparam logic [LSIZE_W-1:0] LMAX = LSIZE_W'(MAX_LATTICE);
    localparam logic [LSIZE_W-1:0] LMIN = LSIZE_W'(2);

    logic [LSIZE_W-1:0]     lsize_reg;
    logic [LY_W-1:0]        ly_reg;
    logic [PLANE_W-1:0]     plane_reg;
    logic [VOL_W-1:0]       vol_reg;
    logic [SETUP_CNT_W-1:0] cnt_reg;
    logic [LSIZE_W-1:0]     rem_a_reg;
    logic [LY_W-1:0]        rem_b_reg;
    logic [RECIP_L_W-1:0]   quo_a_reg;
    logic [RECIP_Y_W-1:0]   quo_b_reg;

    logic [LSIZE_W-1:0]     clamped;
    logic [SETUP_CNT_W-1:0] step;
    logic [LSIZE_W:0]       trial_a;
    logic [LY_W:0]          trial_b;
    logic                   fit_a;
    logic                   fit_b;

    always_comb
    begin
        if (cfg_data < LMIN)
            clamped = LMIN;
        else if (cfg_data > LMAX)
            clamped = LMAX;
        else
            clamped = cfg_data;
    end

    // Restoring division of 2^22 by L and 2^16 by 5L, one quotient bit a cycle.
    assign step    = cnt_reg - SETUP_CNT_W'(1);
    assign trial_a = {rem_a_reg, (step == SETUP_CNT_W'(SHIFT_L))};
    assign trial_b = {rem_b_reg, (step == SETUP_CNT_W'(SHIFT_Y))};
    assign fit_a   = trial_a >= {1'b0, lsize_reg};
    assign fit_b   = trial_b >= {1'b0, ly_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lsize_reg <= LSIZE_W'(10);
            cnt_reg   <= SETUP_CNT_W'(SETUP_CYCLES);
            rem_a_reg <= '0;
            rem_b_reg <= '0;
            quo_a_reg <= '0;
            quo_b_reg <= '0;
        end
        else if (cfg_we)
        begin
            lsize_reg <= clamped;
            cnt_reg   <= SETUP_CNT_W'(SETUP_CYCLES);
            rem_a_reg <= '0;
            rem_b_reg <= '0;
            quo_a_reg <= '0;
            quo_b_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg   <= step;
            rem_a_reg <= fit_a ? LSIZE_W'(trial_a - {1'b0, lsize_reg}) : LSIZE_W'(trial_a);
            quo_a_reg <= {quo_a_reg[RECIP_L_W-2:0], fit_a};
            if (step <= SETUP_CNT_W'(SHIFT_Y))
            begin
                rem_b_reg <= fit_b ? LY_W'(trial_b - {1'b0, ly_reg}) : LY_W'(trial_b);
                quo_b_reg <= {quo_b_reg[RECIP_Y_W-2:0], fit_b};
            end
        end
    end

    // Extents follow the size register through ly_reg, plane_reg and vol_reg, well inside setup.
    always_ff @(posedge clk)
    begin
        ly_reg    <= LY_W'({lsize_reg, 2'b00}) + LY_W'(lsize_reg);
        plane_reg <= PLANE_W'(ly_reg * lsize_reg);
        vol_reg   <= VOL_W'(plane_reg * lsize_reg);
    end

    assign geom.lsize   = lsize_reg;
    assign geom.ly      = ly_reg;
    assign geom.plane   = plane_reg;
    assign geom.vol     = vol_reg;
    assign geom.total   = {vol_reg, 1'b0};
    assign geom.recip_l = quo_a_reg;
    assign geom.recip_y = quo_b_reg;
    assign settling     = cnt_reg != '0;

endmodule

// ===== src/rlne_front.sv =====
// ----------------------------------------------------------------------------
// rlne_front
// Range check and split of the vertex index into x, y, z and w.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rlne_front
    import rlne_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  rlne_in_t   query,
    input  rlne_geom_t geom,
    output logic       push,
    output rlne_item_t item
);

    localparam int NSTG = 8;

    logic [NSTG-1:0]         vld_reg;
    rlne_tag_t               tag_reg [NSTG];
    logic [Q1_W-1:0]         q1e_reg;
    logic [VERTEX_W-1:0]     m1_reg;
    logic [Q1_W-1:0]         q1c_reg;
    logic [Q1_W-1:0]         q1_reg [3:5];
    logic [COORD_W-1:0]      x_reg [3:7];
    logic [Q2_W-1:0]         q2e_reg [4:5];
    logic [Q1_W-1:0]         m2_reg;
    logic [LY_W-1:0]         y_reg [6:7];
    logic [Q2_W-1:0]         q2_reg;
    logic [COORD_W-1:0]      z_reg;
    logic                    w_reg;

    logic [VERTEX_W+RECIP_L_W-1:0] prod_a;
    logic [VERTEX_W-1:0]           r1;
    logic [2*Q1_W-1:0]             prod_b;
    logic [Q1_W-1:0]               r2;
    logic                          wrap_w;

    assign prod_a = (VERTEX_W+RECIP_L_W)'(tag_reg[0].vertex)
                  * (VERTEX_W+RECIP_L_W)'(geom.recip_l);
    assign r1     = tag_reg[2].vertex - m1_reg;
    assign prod_b = (2*Q1_W)'(q1_reg[3]) * (2*Q1_W)'(geom.recip_y);
    assign r2     = q1_reg[5] - m2_reg;
    assign wrap_w = q2_reg >= Q2_W'(geom.lsize);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[NSTG-2:0], accept};
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0].vertex    <= query.vertex;
        tag_reg[0].direction <= query.direction;
        tag_reg[0].negative  <= query.negative;
        tag_reg[0].oor       <= query.vertex >= geom.total;
        for (int i = 1; i < NSTG; i++)
            tag_reg[i] <= tag_reg[i-1];

        // Quotient by L from the reciprocal; it can be one low, fixed below.
        q1e_reg <= prod_a[SHIFT_L+Q1_W-1:SHIFT_L];
        m1_reg  <= VERTEX_W'(q1e_reg * geom.lsize);
        q1c_reg <= q1e_reg;

        if (r1 >= VERTEX_W'(geom.lsize))
        begin
            x_reg[3]  <= COORD_W'(r1 - VERTEX_W'(geom.lsize));
            q1_reg[3] <= q1c_reg + Q1_W'(1);
        end
        else
        begin
            x_reg[3]  <= COORD_W'(r1);
            q1_reg[3] <= q1c_reg;
        end

        q2e_reg[4] <= prod_b[SHIFT_Y+Q2_W-1:SHIFT_Y];
        q1_reg[4]  <= q1_reg[3];
        x_reg[4]   <= x_reg[3];

        m2_reg     <= Q1_W'(q2e_reg[4] * geom.ly);
        q2e_reg[5] <= q2e_reg[4];
        q1_reg[5]  <= q1_reg[4];
        x_reg[5]   <= x_reg[4];

        if (r2 >= Q1_W'(geom.ly))
        begin
            y_reg[6] <= LY_W'(r2 - Q1_W'(geom.ly));
            q2_reg   <= q2e_reg[5] + Q2_W'(1);
        end
        else
        begin
            y_reg[6] <= LY_W'(r2);
            q2_reg   <= q2e_reg[5];
        end
        x_reg[6]  <= x_reg[5];

        // The quotient by the volume is below two, so one compare splits z and w.
        w_reg    <= wrap_w;
        z_reg    <= wrap_w ? COORD_W'(q2_reg - Q2_W'(geom.lsize)) : COORD_W'(q2_reg);
        y_reg[7] <= y_reg[6];
        x_reg[7] <= x_reg[6];
    end

    assign push     = vld_reg[NSTG-1];
    assign item.tag = tag_reg[NSTG-1];
    assign item.x   = x_reg[7];
    assign item.y   = y_reg[7];
    assign item.z   = z_reg;
    assign item.w   = w_reg;

endmodule

// ===== src/rlne_queue.sv =====
// ----------------------------------------------------------------------------
// rlne_queue
// Short queue of split items between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rlne_queue
    import rlne_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  rlne_item_t push_item,
    input  logic       pop,
    output logic       not_empty,
    output rlne_item_t head
);

    localparam int DEPTH = 4;
    localparam int PTR_W = 2;

    rlne_item_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;
    logic             do_pop;

    assign not_empty = count_reg != '0;
    assign do_pop    = pop && not_empty;
    assign head      = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            count_reg <= count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_item;
    end

endmodule

// ===== src/rlne_back.sv =====
// ----------------------------------------------------------------------------
// rlne_back
// Steps to the neighbor, rebuilds its index and forms the edge index.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rlne_back
    import rlne_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       valid,
    input  rlne_item_t item,
    input  rlne_geom_t geom,
    output logic       done,
    output rlne_out_t  result
);

    logic [2:0]          vld_reg;
    rlne_tag_t           tag_reg [3];
    logic [COORD_W-1:0]  nx_reg;
    logic [LY_W-1:0]     ny_reg;
    logic [COORD_W-1:0]  nz_reg;
    logic                nw_reg;
    logic [COORD_W-1:0]  px_reg;
    logic [VERTEX_W-1:0] py_reg;
    logic [VERTEX_W-1:0] pz_reg;
    logic [VERTEX_W-1:0] pw_reg;
    logic [VERTEX_W-1:0] nb_reg;
    logic                done_reg;
    rlne_out_t           result_reg;

    logic                pos;
    logic                odd_x;
    logic                odd_y;
    logic                odd_z;
    logic                dx;
    logic                dy;
    logic                dz;
    logic [COORD_W-1:0]  step_x;
    logic [LY_W-1:0]     step_y;
    logic [COORD_W-1:0]  step_z;
    logic [VERTEX_W-1:0] low_end;

    assign pos = ~item.tag.negative;

    always_comb
    begin
        odd_x = 1'b0;
        odd_y = 1'b0;
        odd_z = 1'b0;
        unique case (item.tag.direction)
            DIR_XY:  odd_z = 1'b1;
            DIR_XZ:  odd_y = 1'b1;
            DIR_YZ:  odd_x = 1'b1;
            DIR_XYZ: ;
            default: ;
        endcase
    end

    // From w=1 the paired axes move with a positive step; from w=0 with a negative one.
    always_comb
    begin
        if (item.w)
        begin
            dx = odd_x ? item.tag.negative : pos;
            dy = odd_y ? item.tag.negative : pos;
            dz = odd_z ? item.tag.negative : pos;
            step_x = (!dx) ? item.x :
                     (7'(item.x) + 7'd1 >= geom.lsize) ? '0 : item.x + COORD_W'(1);
            step_y = (!dy) ? item.y :
                     (10'(item.y) + 10'd1 >= 10'(geom.ly)) ? '0 : item.y + LY_W'(1);
            step_z = (!dz) ? item.z :
                     (7'(item.z) + 7'd1 >= geom.lsize) ? '0 : item.z + COORD_W'(1);
        end
        else
        begin
            dx = odd_x ? pos : item.tag.negative;
            dy = odd_y ? pos : item.tag.negative;
            dz = odd_z ? pos : item.tag.negative;
            step_x = (!dx) ? item.x :
                     (item.x == '0) ? COORD_W'(geom.lsize - 7'd1) : item.x - COORD_W'(1);
            step_y = (!dy) ? item.y :
                     (item.y == '0) ? geom.ly - LY_W'(1) : item.y - LY_W'(1);
            step_z = (!dz) ? item.z :
                     (item.z == '0) ? COORD_W'(geom.lsize - 7'd1) : item.z - COORD_W'(1);
        end
    end

    assign low_end = tag_reg[2].negative ? nb_reg : tag_reg[2].vertex;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[1:0], valid};
            done_reg <= vld_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0] <= item.tag;
        tag_reg[1] <= tag_reg[0];
        tag_reg[2] <= tag_reg[1];

        nx_reg <= step_x;
        ny_reg <= step_y;
        nz_reg <= step_z;
        nw_reg <= ~item.w;

        px_reg <= nx_reg;
        py_reg <= VERTEX_W'(ny_reg * geom.lsize);
        pz_reg <= VERTEX_W'(nz_reg * geom.plane);
        pw_reg <= nw_reg ? VERTEX_W'(geom.vol) : '0;

        nb_reg <= VERTEX_W'(px_reg) + py_reg + pz_reg + pw_reg;

        if (tag_reg[2].oor)
        begin
            result_reg.neighbor     <= '0;
            result_reg.edge_res     <= '0;
            result_reg.out_of_range <= 1'b1;
        end
        else
        begin
            result_reg.neighbor     <= nb_reg;
            result_reg.edge_res     <= {low_end, 2'b00} + EDGE_W'(tag_reg[2].direction);
            result_reg.out_of_range <= 1'b0;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== src/rhombic_lattice_neighbor_edge_index_core.sv =====
// ----------------------------------------------------------------------------
// rhombic_lattice_neighbor_edge_index_core
// Neighbor vertex and edge index on a periodic two-sublattice rhombic lattice.
// ----------------------------------------------------------------------------
//  Channel   Ports                          Handshake
//  query     start, busy, query             taken when start && !busy
//  result    done, result                   valid for the one cycle done is high
//  config    cfg_we, cfg_data               written when cfg_we is high
//
// One query is taken every cycle while busy is low; each result appears in
// order. The lattice size is turned into reciprocals by a bit-serial
// divider, so busy is high after reset and after each configuration write
// until the divider is done. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rhombic_lattice_neighbor_edge_index_core
    import rlne_pkg::*;
#(
    parameter int MAX_LATTICE = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  rlne_in_t           query,
    output logic               done,
    output rlne_out_t          result,
    input  logic               cfg_we,
    input  logic [LSIZE_W-1:0] cfg_data
);

    rlne_geom_t geom;
    logic       settling;
    logic       accept;
    logic       push;
    rlne_item_t push_item;
    logic       not_empty;
    rlne_item_t head;

    assign busy   = settling;
    assign accept = start && !settling;

    rlne_setup #(
        .MAX_LATTICE(MAX_LATTICE)
    ) u_setup (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .geom     (geom),
        .settling (settling)
    );

    rlne_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .query  (query),
        .geom   (geom),
        .push   (push),
        .item   (push_item)
    );

    rlne_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (1'b1),
        .not_empty (not_empty),
        .head      (head)
    );

    rlne_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .valid  (not_empty),
        .item   (head),
        .geom   (geom),
        .done   (done),
        .result (result)
    );

endmodule

// ===== src/rlne_checker.sv =====
// ----------------------------------------------------------------------------
// rlne_checker
// Port-level checks for the rhombic lattice neighbor/edge index core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rlne_checker
    import rlne_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      busy,
    input logic      done,
    input rlne_out_t result,
    input logic      cfg_we
);

    // A write restarts the reciprocal setup, so queries are held off next cycle.
    a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> busy)
        else $error("busy not raised after a configuration write");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.out_of_range |-> result.neighbor == '0 && result.edge_res == '0)
        else $error("out-of-range result carries nonzero fields");

    a_nb_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.neighbor < VERTEX_W'(2621440))
        else $error("neighbor index beyond the largest lattice");

    a_edge_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.edge_res < EDGE_W'(10485760))
        else $error("edge index beyond the largest lattice");

endmodule

bind rhombic_lattice_neighbor_edge_index_core rlne_checker u_rlne_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .busy   (busy),
    .done   (done),
    .result (result),
    .cfg_we (cfg_we)
);

// ===== test/tb_rhombic_lattice_neighbor_edge_index_core.sv =====
// ----------------------------------------------------------------------------
// tb_rhombic_lattice_neighbor_edge_index_core
// Drives neighbor/edge requests into the lattice core under several lattice
// sizes, predicts each result, and checks every result field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rhombic_lattice_neighbor_edge_index_core;
    import rlne_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    rlne_in_t           query;
    logic               done;
    rlne_out_t          result;
    logic               cfg_we;
    logic [LSIZE_W-1:0] cfg_data;

    rlne_out_t          expected_results[$];
    logic [LSIZE_W-1:0] lattice_reg;
    int                 error_count;
    bit                 idling_on;

    rhombic_lattice_neighbor_edge_index_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .query    (query),
        .done     (done),
        .result   (result),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always #4 clk = ~clk;

    // Effective lattice size after saturation to the legal range.
    function automatic int unsigned eff_size(logic [LSIZE_W-1:0] raw);
        if (raw < 2)
            return 2;
        if (raw > 64)
            return 64;
        return 32'(raw);
    endfunction

    function automatic int unsigned vertex_total();
        int unsigned l;
        l = eff_size(lattice_reg);
        return 10 * l * l * l;
    endfunction

    function automatic rlne_out_t predict_neighbor(rlne_in_t q, logic [LSIZE_W-1:0] raw);
        int unsigned l, ly, plane, vol, v, x, y, z, w, nb;
        bit          neg, pos, sx, sy, sz;
        rlne_out_t   r;
        l     = eff_size(raw);
        ly    = 5 * l;
        plane = ly * l;
        vol   = plane * l;
        v     = 32'(q.vertex);
        neg   = q.negative;
        pos   = !neg;
        r     = '0;
        if (v >= 2 * vol)
        begin
            r.out_of_range = 1'b1;
            return r;
        end
        x = v % l;
        y = (v / l) % ly;
        z = (v / plane) % l;
        w = (v / vol) & 1;
        // The odd axis moves against the paired axes.
        if (w != 0)
        begin
            sx = (q.direction == DIR_YZ) ? neg : pos;
            sy = (q.direction == DIR_XZ) ? neg : pos;
            sz = (q.direction == DIR_XY) ? neg : pos;
            if (sx) x = (x + 1 >= l) ? 0 : x + 1;
            if (sy) y = (y + 1 >= ly) ? 0 : y + 1;
            if (sz) z = (z + 1 >= l) ? 0 : z + 1;
        end
        else
        begin
            sx = (q.direction == DIR_YZ) ? pos : neg;
            sy = (q.direction == DIR_XZ) ? pos : neg;
            sz = (q.direction == DIR_XY) ? pos : neg;
            if (sx) x = (x == 0) ? l - 1 : x - 1;
            if (sy) y = (y == 0) ? ly - 1 : y - 1;
            if (sz) z = (z == 0) ? l - 1 : z - 1;
        end
        w  = w ^ 1;
        nb = x + y * l + z * plane + w * vol;
        r.neighbor = nb[VERTEX_W-1:0];
        r.edge_res = EDGE_W'(4 * (neg ? nb : v) + q.direction);
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    // Sends one request, leaving start high so back-to-back requests need no toggle.
    task automatic send_query(logic [VERTEX_W-1:0] v, logic [1:0] dir, logic neg);
        rlne_in_t q;
        q.vertex    = v;
        q.direction = dir;
        q.negative  = neg;
        if (idling_on && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        start <= 1'b1;
        query <= q;
        do
            @(posedge clk);
        while (busy);
        expected_results = {expected_results, predict_neighbor(q, lattice_reg)};
    endtask

    task automatic set_lattice(logic [LSIZE_W-1:0] val);
        start <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= val;
        @(posedge clk);
        cfg_we      <= 1'b0;
        lattice_reg  = val;
        repeat (2) @(posedge clk);
    endtask

    task automatic send_random(int n, int oor_pct);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < oor_pct)
                send_query(VERTEX_W'($urandom), 2'($urandom), 1'($urandom));
            else
                send_query(VERTEX_W'($urandom_range(0, vertex_total() - 1)),
                           2'($urandom), 1'($urandom));
        end
    endtask

    // Corners of the index space at the reset lattice size, every direction and sign.
    task automatic test_directed();
        int unsigned tot;
        tot = vertex_total();
        for (int d = 0; d < 4; d++)
        begin
            send_query(VERTEX_W'(0), 2'(d), 1'b0);
            send_query(VERTEX_W'(0), 2'(d), 1'b1);
            send_query(VERTEX_W'(tot - 1), 2'(d), 1'b0);
            send_query(VERTEX_W'(tot - 1), 2'(d), 1'b1);
            send_query(VERTEX_W'(tot / 2), 2'(d), 1'($urandom));
        end
        send_query(VERTEX_W'(tot / 2 - 1), DIR_XYZ, 1'b0);
        send_query(VERTEX_W'(tot), DIR_XY, 1'b0);
        send_query({VERTEX_W{1'b1}}, DIR_XYZ, 1'b1);
    endtask

    // Register values outside 2..64 must saturate.
    task automatic test_saturation();
        logic [LSIZE_W-1:0] vals[4] = '{7'd0, 7'd1, 7'd65, 7'd127};
        foreach (vals[i])
        begin
            set_lattice(vals[i]);
            send_query(VERTEX_W'(0), DIR_XY, 1'b1);
            send_query(VERTEX_W'(vertex_total() - 1), DIR_XYZ, 1'b0);
            send_random(6, 10);
        end
    endtask

    task automatic test_random();
        logic [LSIZE_W-1:0] sizes[5] = '{7'd2, 7'd64, 7'd3, 7'd37, 7'd0};
        sizes[4] = 7'($urandom_range(2, 64));
        foreach (sizes[i])
        begin
            set_lattice(sizes[i]);
            if (i == 4)
                idling_on = 1'b0;
            send_random(90, 8);
        end
    endtask

    always @(posedge clk)
    begin
        rlne_out_t want;
        if (done)
        begin
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected result", 1, 0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result.neighbor !== want.neighbor)
                    report_mismatch("neighbor", result.neighbor, want.neighbor);
                if (result.edge_res !== want.edge_res)
                    report_mismatch("edge_res", result.edge_res, want.edge_res);
                if (result.out_of_range !== want.out_of_range)
                    report_mismatch("out_of_range", result.out_of_range, want.out_of_range);
            end
        end
    end

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        query       = '0;
        cfg_we      = 1'b0;
        cfg_data    = '0;
        lattice_reg = 7'd10;
        error_count = 0;
        idling_on   = 1'b1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_saturation();
        test_random();
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/rlne_pkg.sv
src/rlne_setup.sv
src/rlne_front.sv
src/rlne_queue.sv
src/rlne_back.sv
src/rhombic_lattice_neighbor_edge_index_core.sv
src/rlne_checker.sv
test/tb_rhombic_lattice_neighbor_edge_index_core.sv
